// ===== hw/rtl/lptd_pkg.sv =====
// Shared types, constants and register codes of the load probe trigger detector.
package lptd_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int MAG_W    = 23;
	localparam int NF_W     = 12;
	localparam int NF_FRAC  = 8;
	localparam int CNT_W    = 8;
	localparam int BUSY_W   = 10;
	localparam int WGT_W    = 16;
	localparam int WGT_FRAC = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int NOISE_INIT = 180;

	localparam logic [MAG_W-1:0]  MAX_MAG_RST   = MAG_W'(800000);
	localparam logic [NF_W-1:0]   NF_RST        = NF_W'(896);
	localparam logic [MAG_W-1:0]  ABS_THR_RST   = MAG_W'(3000);
	localparam logic [CNT_W-1:0]  MIN_HIGH_RST  = CNT_W'(2);
	localparam logic [CNT_W-1:0]  HOLD_RST      = CNT_W'(4);
	localparam logic [BUSY_W-1:0] RST_LIMIT_RST = BUSY_W'(100);
	localparam logic [WGT_W-1:0]  LOAD_WGT_RST  = WGT_W'(19661);
	localparam logic [WGT_W-1:0]  NOISE_WGT_RST = WGT_W'(66);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_MAG   = 3'd0,
		REG_NF        = 3'd1,
		REG_ABS_THR   = 3'd2,
		REG_MIN_HIGH  = 3'd3,
		REG_HOLD      = 3'd4,
		REG_RST_LIMIT = 3'd5,
		REG_LOAD_WGT  = 3'd6,
		REG_NOISE_WGT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0]  max_magnitude;
		logic [NF_W-1:0]   noise_factor_q8;
		logic [MAG_W-1:0]  press_level;
		logic [CNT_W-1:0]  min_run_steps;
		logic [CNT_W-1:0]  hold_steps;
		logic [BUSY_W-1:0] reset_limit;
		logic [WGT_W-1:0]  load_weight_q16;
		logic [WGT_W-1:0]  noise_weight_q16;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LEVEL,
		ST_DECIDE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic eval;
		logic level;
		logic decide;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic reset_hit;
		logic overrange;
	} dp_status_t;

endpackage

// ===== hw/rtl/load_probe_trigger_detector_unit.sv =====
// Top level of the load probe trigger detector: config registers, sequencer, datapath.
// Sequence: a filtered sample passes the eval, level, decide and finish states; a rejected
//   or reset-step sample goes from eval straight to finish.
// Flow: one sample is in work at a time, paced by the shared weight multiplier and the state
//   sequence; the next is taken at finish while a result waits, and a stalled beat holds finish.
// Reset: arst_n resets the filters, counters and trigger state and loads register defaults.
module load_probe_trigger_detector_unit
	import lptd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   trigger,
	output logic                   tare_request,
	output logic                   sample_rejected,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	lptd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lptd_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.sample          (sample),
		.trigger         (trigger),
		.tare_request    (tare_request),
		.sample_rejected (sample_rejected)
	);

	a_tare_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!tare_request || sample_rejected))
		else $error("tare beat without reject flag");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second sample accepted while one is in work");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.eval, cmd.level, cmd.decide, cmd.finish}))
		else $error("sequencer issued overlapping commands");

endmodule

// ===== hw/rtl/lptd_cfg.sv =====
// Configuration register file of the load probe trigger detector.
module lptd_cfg
	import lptd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_magnitude    <= MAX_MAG_RST;
			cfg_q.noise_factor_q8  <= NF_RST;
			cfg_q.press_level      <= ABS_THR_RST;
			cfg_q.min_run_steps    <= MIN_HIGH_RST;
			cfg_q.hold_steps       <= HOLD_RST;
			cfg_q.reset_limit      <= RST_LIMIT_RST;
			cfg_q.load_weight_q16  <= LOAD_WGT_RST;
			cfg_q.noise_weight_q16 <= NOISE_WGT_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_MAX_MAG:   cfg_q.max_magnitude    <= wr_data[MAG_W-1:0];
				REG_NF:        cfg_q.noise_factor_q8  <= wr_data[NF_W-1:0];
				REG_ABS_THR:   cfg_q.press_level      <= wr_data[MAG_W-1:0];
				REG_MIN_HIGH:  cfg_q.min_run_steps    <= wr_data[CNT_W-1:0];
				REG_HOLD:      cfg_q.hold_steps       <= wr_data[CNT_W-1:0];
				REG_RST_LIMIT: cfg_q.reset_limit      <= wr_data[BUSY_W-1:0];
				REG_LOAD_WGT:  cfg_q.load_weight_q16  <= wr_data[WGT_W-1:0];
				REG_NOISE_WGT: cfg_q.noise_weight_q16 <= wr_data[WGT_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/lptd_ctrl.sv =====
// Sequencer and output beat handshake of the load probe trigger detector.
module lptd_ctrl
	import lptd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (status.reset_hit || status.overrange) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt  = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					in_stall   = 1'b0;
					if (in_valid) begin
						cmd.take  = 1'b1;
						state_nxt = ST_EVAL;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/lptd_dp.sv =====
// Filter, detection and counter datapath of the load probe trigger detector.
module lptd_dp
	import lptd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   trigger,
	output logic                   tare_request,
	output logic                   sample_rejected
);

	localparam int S      = SAMPLE_BITS;
	localparam int F      = FRAC_BITS;
	localparam int LW     = S + F + 1;
	localparam int DW     = LW + 1;
	localparam int NB     = S + F;
	localparam int MW     = S + F + 3;
	localparam int PW     = MW + WGT_W + 1;
	localparam int NFW    = NB + NF_W;
	localparam int MAGC_W = ((S > MAG_W) ? S : MAG_W) + 1;
	localparam int THR_W  = ((S > MAG_W) ? S : MAG_W) + F + 2;

	localparam logic [NB-1:0]     NOISE_RST = NB'(NOISE_INIT) << F;
	localparam logic [CNT_W-1:0]  HIGH_MAX  = '1;
	localparam logic [BUSY_W-1:0] BUSY_MAX  = '1;

	// architectural state
	logic signed [LW-1:0] smoothed_q, prev_q;
	logic [NB-1:0]        noise_q;
	logic [CNT_W-1:0]     high_q, hold_q;
	logic [BUSY_W-1:0]    busy_q;
	logic                 trig_q;
	logic                 noise_upd_q;

	// per-beat working registers
	logic [S-1:0]         x_q;
	logic signed [PW-1:0] prod_q;
	logic [NFW-1:0]       nfprod_q;
	logic signed [DW-1:0] delta_q;
	logic                 rst_step_q, ovr_step_q;
	logic                 out_trig_q, out_tare_q, out_rej_q;

	logic [S-1:0]          mag;
	logic                  reset_hit, overrange;
	logic signed [MW-1:0]  target, diff, err, mul_a, scaled;
	logic signed [WGT_W:0] mul_b;
	logic signed [PW-1:0]  mul_p;
	logic signed [LW-1:0]  new_lvl;
	logic signed [DW-1:0]  delta;
	logic [LW-1:0]         abs_delta;
	logic signed [THR_W-1:0] thr_mag, neg_thr;
	logic                  drop_hi, lvl_hi, is_high;
	logic [CNT_W-1:0]      high_nxt;
	logic [BUSY_W-1:0]     busy_inc;
	logic signed [MW:0]    noise_sum, noise_lim;
	logic [NB-1:0]         noise_nxt;

	assign mag       = x_q[S-1] ? (~x_q + 1'b1) : x_q;
	assign reset_hit = busy_q > cfg.reset_limit;
	assign overrange = MAGC_W'(mag) > MAGC_W'(cfg.max_magnitude);
	assign status    = '{reset_hit: reset_hit, overrange: overrange};

	assign target = MW'($signed({x_q, {F{1'b0}}}));
	assign diff   = target - MW'(smoothed_q);

	assign abs_delta = delta_q[DW-1] ? LW'(-delta_q) : LW'(delta_q);
	assign err       = MW'($signed({1'b0, abs_delta})) - MW'($signed({1'b0, noise_q}));

	// one multiplier serves the level filter and the noise filter
	always_comb begin
		if (cmd.eval) begin
			mul_a = diff;
			mul_b = $signed({1'b0, cfg.load_weight_q16});
		end else begin
			mul_a = err;
			mul_b = $signed({1'b0, cfg.noise_weight_q16});
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign scaled = prod_q[WGT_FRAC +: MW];

	assign new_lvl = smoothed_q + LW'(scaled);
	assign delta   = DW'(new_lvl) - DW'(prev_q);

	assign drop_hi = delta_q[DW-1]
		&& (NFW'(nfprod_q) < NFW'({abs_delta, {NF_FRAC{1'b0}}}));
	assign thr_mag = THR_W'({cfg.press_level, {F{1'b0}}});
	assign neg_thr = -thr_mag;
	assign lvl_hi  = THR_W'(smoothed_q) < neg_thr;
	assign is_high = drop_hi || lvl_hi;

	always_comb begin
		if (!is_high) begin
			high_nxt = '0;
		end else if (high_q == HIGH_MAX) begin
			high_nxt = high_q;
		end else begin
			high_nxt = high_q + 1'b1;
		end
	end

	assign busy_inc = (busy_q == BUSY_MAX) ? busy_q : busy_q + 1'b1;

	assign noise_sum = (MW + 1)'($signed({1'b0, noise_q})) + (MW + 1)'(scaled);
	assign noise_lim = {{(MW + 1 - NB){1'b0}}, {NB{1'b1}}};

	always_comb begin
		if (noise_sum[MW]) begin
			noise_nxt = '0;
		end else if (noise_sum > noise_lim) begin
			noise_nxt = '1;
		end else begin
			noise_nxt = noise_sum[NB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q  <= '0;
			prev_q      <= '0;
			noise_q     <= NOISE_RST;
			high_q      <= '0;
			hold_q      <= '0;
			busy_q      <= '0;
			trig_q      <= 1'b0;
			noise_upd_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				noise_upd_q <= 1'b0;
				if (reset_hit) begin
					smoothed_q <= '0;
					prev_q     <= '0;
					noise_q    <= NOISE_RST;
					high_q     <= '0;
					hold_q     <= '0;
					busy_q     <= '0;
				end else if (overrange) begin
					busy_q <= busy_inc;
				end
			end
			if (cmd.level) begin
				smoothed_q <= new_lvl;
				prev_q     <= new_lvl;
			end
			if (cmd.decide) begin
				high_q <= high_nxt;
				priority if (high_nxt >= cfg.min_run_steps) begin
					trig_q <= 1'b1;
					busy_q <= busy_inc;
					hold_q <= '0;
				end else if (hold_q < cfg.hold_steps) begin
					trig_q <= 1'b1;
					busy_q <= busy_inc;
					hold_q <= hold_q + 1'b1;
				end else begin
					trig_q      <= 1'b0;
					busy_q      <= '0;
					noise_upd_q <= 1'b1;
				end
			end
			if (cmd.finish && noise_upd_q) begin
				noise_q <= noise_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q <= sample;
		end
		if (cmd.eval) begin
			prod_q     <= mul_p;
			nfprod_q   <= noise_q * cfg.noise_factor_q8;
			rst_step_q <= reset_hit;
			ovr_step_q <= overrange && !reset_hit;
		end
		if (cmd.level) begin
			delta_q <= delta;
		end
		if (cmd.decide) begin
			prod_q <= mul_p;
		end
		if (cmd.finish) begin
			out_trig_q <= trig_q;
			out_tare_q <= rst_step_q;
			out_rej_q  <= rst_step_q || ovr_step_q;
		end
	end

	assign trigger         = out_trig_q;
	assign tare_request    = out_tare_q;
	assign sample_rejected = out_rej_q;

endmodule

// ===== tb/lptd_checker.sv =====
`timescale 1ns / 100ps
// Detector checker: watches sample, result and register beats, predicts each result and compares.
module lptd_checker
	import lptd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [SAMPLE_BITS_DEF-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       trigger,
	input  logic                       tare_request,
	input  logic                       sample_rejected,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         fail_count,
	output int                         pending
);

	localparam int     FRAC      = FRAC_BITS_DEF;
	localparam int     HIGH_SAT  = 255;
	localparam int     BUSY_SAT  = 1023;
	localparam longint NOISE_SAT = (longint'(1) <<< (SAMPLE_BITS_DEF + FRAC_BITS_DEF)) - 1;

	typedef struct packed {
		logic trigger;
		logic tare;
		logic rejected;
	} outcome_t;

	cfg_t     regs;
	longint   level;
	longint   prev_level;
	longint   noise;
	int       high_cnt;
	int       hold_cnt;
	int       busy_cnt;
	logic     trig_level;
	outcome_t outcomes_due[$];
	outcome_t got;
	outcome_t want;
	int       bad;

	// floor(d * w / 2^16)
	function automatic longint floor_q16(input longint d, input longint w);
		return (d * w) >>> WGT_FRAC;
	endfunction

	// trigger level is left alone on purpose
	function automatic void clear_filters();
		level      = 0;
		prev_level = 0;
		noise      = longint'(NOISE_INIT) <<< FRAC;
		high_cnt   = 0;
		hold_cnt   = 0;
		busy_cnt   = 0;
	endfunction

	function automatic outcome_t advance_detector(input logic signed [SAMPLE_BITS_DEF-1:0] s);
		longint   x;
		longint   mag;
		longint   delta;
		longint   absdelta;
		longint   drop;
		longint   n;
		logic     high;
		outcome_t r;
		x          = s;
		r.trigger  = trig_level;
		r.tare     = 1'b0;
		r.rejected = 1'b0;
		if (busy_cnt > int'(regs.reset_limit)) begin
			clear_filters();
			r.tare     = 1'b1;
			r.rejected = 1'b1;
			return r;
		end
		mag = (x < 0) ? -x : x;
		if (mag > longint'(regs.max_magnitude)) begin
			if (busy_cnt < BUSY_SAT)
				busy_cnt++;
			r.rejected = 1'b1;
			return r;
		end
		level      = level + floor_q16((x <<< FRAC) - level, longint'(regs.load_weight_q16));
		delta      = level - prev_level;
		absdelta   = (delta < 0) ? -delta : delta;
		prev_level = level;
		drop       = -delta;
		high       = 1'b0;
		if (drop > 0) begin
			if (regs.noise_factor_q8 == '0)
				high = 1'b1;
			else if (noise <= ((drop <<< NF_FRAC) - 1) / longint'(regs.noise_factor_q8))
				high = 1'b1;
		end
		if (level < -(longint'(regs.press_level) <<< FRAC))
			high = 1'b1;
		if (!high)
			high_cnt = 0;
		else if (high_cnt < HIGH_SAT)
			high_cnt++;
		if (high_cnt >= int'(regs.min_run_steps)) begin
			trig_level = 1'b1;
			if (busy_cnt < BUSY_SAT)
				busy_cnt++;
			hold_cnt = 0;
		end else if (hold_cnt < int'(regs.hold_steps)) begin
			trig_level = 1'b1;
			if (busy_cnt < BUSY_SAT)
				busy_cnt++;
			hold_cnt++;
		end else begin
			trig_level = 1'b0;
			busy_cnt   = 0;
			n = noise + floor_q16(absdelta - noise, longint'(regs.noise_weight_q16));
			if (n < 0)
				n = 0;
			if (n > NOISE_SAT)
				n = NOISE_SAT;
			noise = n;
		end
		r.trigger = trig_level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{max_magnitude: MAX_MAG_RST, noise_factor_q8: NF_RST,
				press_level: ABS_THR_RST, min_run_steps: MIN_HIGH_RST,
				hold_steps: HOLD_RST, reset_limit: RST_LIMIT_RST,
				load_weight_q16: LOAD_WGT_RST, noise_weight_q16: NOISE_WGT_RST};
			clear_filters();
			trig_level = 1'b0;
			outcomes_due.delete();
			bad = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.trigger  = trigger;
				got.tare     = tare_request;
				got.rejected = sample_rejected;
				if (outcomes_due.size() == 0) begin
					if (bad < 10)
						$display("%0t: unexpected result beat trigger/tare/rejected %b/%b/%b",
							$time, got.trigger, got.tare, got.rejected);
					bad++;
				end else begin
					want = outcomes_due.pop_front();
					if (got !== want) begin
						if (bad < 10)
							$display("%0t: trigger/tare/rejected expected %b/%b/%b, got %b/%b/%b",
								$time, want.trigger, want.tare, want.rejected,
								got.trigger, got.tare, got.rejected);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall)
				outcomes_due.push_back(advance_detector(sample));
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_MAG:   regs.max_magnitude    = cfg_data[MAG_W-1:0];
					REG_NF:        regs.noise_factor_q8  = cfg_data[NF_W-1:0];
					REG_ABS_THR:   regs.press_level      = cfg_data[MAG_W-1:0];
					REG_MIN_HIGH:  regs.min_run_steps    = cfg_data[CNT_W-1:0];
					REG_HOLD:      regs.hold_steps       = cfg_data[CNT_W-1:0];
					REG_RST_LIMIT: regs.reset_limit      = cfg_data[BUSY_W-1:0];
					REG_LOAD_WGT:  regs.load_weight_q16  = cfg_data[WGT_W-1:0];
					REG_NOISE_WGT: regs.noise_weight_q16 = cfg_data[WGT_W-1:0];
					default:       ;
				endcase
			end
			fail_count <= bad;
			pending    <= outcomes_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample and register traffic, handshake idling and the verdict.
module testbench;
	import lptd_pkg::*;

	localparam int SW         = SAMPLE_BITS_DEF;
	localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;
	localparam int SAMPLE_MIN = -(1 << (SW - 1));

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [SW-1:0]         sample    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  trigger;
	logic                  tare_request;
	logic                  sample_rejected;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_MAX_MAG;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int idle_pct  = 0;
	int stall_pct = 0;
	int sent      = 0;
	int mag_limit = int'(MAX_MAG_RST);

	load_probe_trigger_detector_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.trigger(trigger), .tare_request(tare_request), .sample_rejected(sample_rejected),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lptd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.trigger(trigger), .tare_request(tare_request), .sample_rejected(sample_rejected),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic int jitter(input int amp);
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	task automatic send_sample(input int v);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= SW'(v);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int       directed [22] = '{0, SAMPLE_MAX, SAMPLE_MIN, 800000, -800000, 800001, -800001,
			1, -1, -2000, -6000, -12000, -20000, -30000, 0, 0, 0, 0, 0, 0, 5000, 0};
		cfg_t     c;
		cfg_reg_t r;
		int       start;
		int       pick;
		int       amp;
		int       step;
		int       lvl;
		int       v;
		int       swing;
		swing = SAMPLE_MAX;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: extremes, clean press and release
		foreach (directed[i])
			send_sample(directed[i]);

		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			c = '{max_magnitude: MAX_MAG_RST, noise_factor_q8: NF_RST,
				press_level: ABS_THR_RST, min_run_steps: MIN_HIGH_RST,
				hold_steps: HOLD_RST, reset_limit: RST_LIMIT_RST,
				load_weight_q16: LOAD_WGT_RST, noise_weight_q16: NOISE_WGT_RST};
			case (phase)
				0: begin
					c.reset_limit = BUSY_W'($urandom_range(3, 12));
					c.hold_steps  = CNT_W'($urandom_range(0, 3));
				end
				1: c = '1;
				2: c = '0;
				3: ;
				default: begin
					c.max_magnitude    = MAG_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, SAMPLE_MAX) : $urandom_range(100000, SAMPLE_MAX));
					c.noise_factor_q8  = NF_W'(($urandom_range(0, 3) == 0) ?
						0 : $urandom_range(0, 4095));
					c.press_level      = MAG_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, SAMPLE_MAX) : $urandom_range(0, 20000));
					c.min_run_steps    = CNT_W'($urandom_range(0, 6));
					c.hold_steps       = CNT_W'($urandom_range(0, 12));
					c.reset_limit      = BUSY_W'(($urandom_range(0, 4) == 0) ?
						1023 : $urandom_range(0, 60));
					c.load_weight_q16  = WGT_W'($urandom_range(0, 65535));
					c.noise_weight_q16 = WGT_W'($urandom_range(0, 65535));
				end
			endcase

			r = REG_MAX_MAG;
			do begin
				cfg_valid <= 1'b1;
				cfg_index <= r;
				case (r)
					REG_MAX_MAG:   cfg_data <= CFG_DATA_W'(c.max_magnitude);
					REG_NF:        cfg_data <= CFG_DATA_W'(c.noise_factor_q8);
					REG_ABS_THR:   cfg_data <= CFG_DATA_W'(c.press_level);
					REG_MIN_HIGH:  cfg_data <= CFG_DATA_W'(c.min_run_steps);
					REG_HOLD:      cfg_data <= CFG_DATA_W'(c.hold_steps);
					REG_RST_LIMIT: cfg_data <= CFG_DATA_W'(c.reset_limit);
					REG_LOAD_WGT:  cfg_data <= CFG_DATA_W'(c.load_weight_q16);
					REG_NOISE_WGT: cfg_data <= CFG_DATA_W'(c.noise_weight_q16);
					default:       ;
				endcase
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
				r = r.next();
			end while (r != REG_MAX_MAG);
			cfg_valid <= 1'b0;
			mag_limit = int'(c.max_magnitude);

			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase

			start = sent;
			while (sent - start < ((phase == 2) ? 30 : 86)) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					// quiet baseline, a ramp of contact, then release
					case ($urandom_range(0, 2))
						0: amp = 20;
						1: amp = 300;
						default: amp = 3000;
					endcase
					repeat ($urandom_range(2, 12))
						send_sample(jitter(amp));
					step = $urandom_range(50, 30000);
					if ($urandom_range(0, 4) == 0)
						step = -step;
					lvl = 0;
					repeat ($urandom_range(1, 10)) begin
						lvl = lvl - step - jitter(amp);
						if (lvl < SAMPLE_MIN)
							lvl = SAMPLE_MIN;
						if (lvl > SAMPLE_MAX)
							lvl = SAMPLE_MAX;
						send_sample(lvl);
					end
					repeat ($urandom_range(1, 8))
						send_sample(jitter(amp));
				end else if (pick < 82) begin
					send_sample(int'($urandom));
				end else if (pick < 92) begin
					repeat ($urandom_range(1, 6)) begin
						if (mag_limit >= SAMPLE_MAX)
							v = SAMPLE_MIN;
						else
							v = int'($urandom_range(mag_limit + 1, SAMPLE_MAX));
						if (v != SAMPLE_MIN && $urandom_range(0, 1) == 1)
							v = -v;
						send_sample(v);
					end
				end else if (pick < 97) begin
					repeat ($urandom_range(2, 6)) begin
						swing = -swing;
						send_sample(swing);
					end
				end else begin
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
